FILE: src/lzss_flag_byte_decompressor_unit_macros.svh
// ----------------------------------------------------------------------------
// lzss_flag_byte_decompressor_unit_macros.svh
// assertion macros shared by the decompressor rtl
// ----------------------------------------------------------------------------
`ifndef LZSS_FLAG_BYTE_DECOMPRESSOR_UNIT_MACROS_SVH
`define LZSS_FLAG_BYTE_DECOMPRESSOR_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define LZFBD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LZFBD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lzss_fbd_pkg.sv
// ----------------------------------------------------------------------------
// lzss_fbd_pkg
// shared types and constants of the lzss flag-byte decompressor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lzss_fbd_pkg;

    // history ring
    localparam int unsigned HISTORY_DEPTH_DEF = 4096;

    // token format
    localparam int unsigned      BYTE_W        = 8;
    localparam int unsigned      OFFSET_W      = 12;
    localparam logic [11:0]      OFFSET_MASK   = 12'h0FFF;
    localparam int unsigned      LENGTH_SHIFT  = 12;
    localparam int unsigned      LEN_W         = 5;
    localparam logic [LEN_W-1:0] LENGTH_BIAS   = 5'd2;
    localparam logic [3:0]       FLAGS_PER_BYTE = 4'd8;

    // configuration
    localparam int unsigned LIMIT_W     = 32;
    localparam logic [31:0] LIMIT_RESET = 32'hFFFF_FFFF;

    // request from the decoder to the history ring
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [BYTE_W-1:0] wr_data;
    } hist_req_t;

endpackage

FILE: src/lzss_flag_byte_decompressor_unit.sv
// ----------------------------------------------------------------------------
// lzss_flag_byte_decompressor_unit
// lzss flag-byte decompressor with a 4096-byte history ring
// ----------------------------------------------------------------------------
// Compressed bytes enter on the s_ channel, one per beat, with s_in_last on
// the final byte of a stream. Decompressed bytes leave on the m_ channel;
// m_run_last marks the last byte produced by one input beat.
// Flag bytes, pair low bytes and literals are each taken on a single beat; a
// literal appears on m_ in the cycle after its beat. A pair high byte starts
// a copy of 2 to 17 bytes: a first ring read, then one byte per cycle unless
// the output register is held, and no new beat is taken until the copy ends.
// The single ring read port with its registered read sets this pace.
// Output is held in a register; a new beat is taken only while that register
// is empty or is being read in the same cycle, so when m_ready stays low the
// block waits with it. Bytes past output_limit are decoded into the ring but
// not sent.
// Reset (and the end of every stream) empties the ring at once through a
// fill count; no clearing pass is needed. cfg_wr_en writes output_limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzss_flag_byte_decompressor_unit #(
    parameter int unsigned HISTORY_DEPTH = lzss_fbd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [lzss_fbd_pkg::LIMIT_W-1:0] cfg_wr_data,
    // compressed input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [lzss_fbd_pkg::BYTE_W-1:0]  s_in_byte,
    input  logic                             s_in_last,
    // decompressed output
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [lzss_fbd_pkg::BYTE_W-1:0]  m_out_byte,
    output logic                             m_run_last
);
    import lzss_fbd_pkg::*;

`include "lzss_flag_byte_decompressor_unit_macros.svh"

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } state_t;

    state_t             state_reg, state_next;
    logic               phase_reg, phase_next;
    logic [BYTE_W-1:0]  flags_reg, flags_next;
    logic [3:0]         rem_reg, rem_next;
    logic [BYTE_W-1:0]  low_reg, low_next;
    logic [LIMIT_W-1:0] emitted_reg, emitted_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]      src_reg, src_next;
    logic               last_reg, last_next;
    logic               mv_reg, mv_next;
    logic [BYTE_W-1:0]  mbyte_reg, mbyte_next;
    logic               mlast_reg, mlast_next;

    hist_req_t          hreq;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_pos;
    logic [BYTE_W-1:0]  rd_data;
    logic               clear;

    logic               can_load, emit_ok, at_limit, s_fire;
    logic [15:0]        code;
    logic [OFFSET_W-1:0] offset;

    // history ring
    lzss_fbd_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (clear),
        .req     (hreq),
        .rd_addr (rd_addr),
        .wr_pos  (wr_pos),
        .rd_data (rd_data)
    );

    assign can_load = !mv_reg || m_ready;
    assign emit_ok  = emitted_reg < limit_reg;
    assign at_limit = (emitted_reg + LIMIT_W'(1)) == limit_reg;
    assign s_ready  = (state_reg == ST_IDLE) && can_load;
    assign s_fire   = s_valid && s_ready;
    assign code     = {s_in_byte, low_reg};
    assign offset   = code[OFFSET_W-1:0] & OFFSET_MASK;

    // token decode and copy sequencing
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        flags_next   = flags_reg;
        rem_next     = rem_reg;
        low_next     = low_reg;
        emitted_next = emitted_reg;
        cnt_next     = cnt_reg;
        src_next     = src_reg;
        last_next    = last_reg;
        mv_next      = m_ready ? 1'b0 : mv_reg;
        mbyte_next   = mbyte_reg;
        mlast_next   = mlast_reg;
        hreq         = '0;
        rd_addr      = src_reg;
        clear        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (phase_reg) begin
                        // pair high byte: start the copy with its first read
                        rd_addr    = wr_pos - AW'(offset);
                        hreq.rd_en = 1'b1;
                        src_next   = rd_addr + AW'(1);
                        cnt_next   = LEN_W'(code[15:LENGTH_SHIFT]) + LENGTH_BIAS;
                        last_next  = s_in_last;
                        phase_next = 1'b0;
                        state_next = ST_COPY;
                    end else if (rem_reg == '0) begin
                        // flag byte
                        flags_next = s_in_byte;
                        rem_next   = FLAGS_PER_BYTE;
                        clear      = s_in_last;
                    end else begin
                        flags_next = flags_reg >> 1;
                        rem_next   = rem_reg - 4'd1;
                        if (flags_reg[0]) begin
                            // literal
                            hreq.wr_en   = 1'b1;
                            hreq.wr_data = s_in_byte;
                            if (emit_ok) begin
                                mv_next      = 1'b1;
                                mbyte_next   = s_in_byte;
                                mlast_next   = 1'b1;
                                emitted_next = emitted_reg + LIMIT_W'(1);
                            end
                        end else begin
                            // pair low byte
                            low_next   = s_in_byte;
                            phase_next = 1'b1;
                        end
                        clear = s_in_last;
                    end
                end
            end
            ST_COPY: begin
                if (!emit_ok || can_load) begin
                    // append the copied byte and send it when under the limit
                    hreq.wr_en   = 1'b1;
                    hreq.wr_data = rd_data;
                    if (emit_ok) begin
                        mv_next      = 1'b1;
                        mbyte_next   = rd_data;
                        mlast_next   = (cnt_reg == LEN_W'(1)) || at_limit;
                        emitted_next = emitted_reg + LIMIT_W'(1);
                    end
                    cnt_next = cnt_reg - LEN_W'(1);
                    if (cnt_reg == LEN_W'(1)) begin
                        state_next = ST_IDLE;
                        clear      = last_reg;
                    end else begin
                        hreq.rd_en = 1'b1;
                        src_next   = src_reg + AW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // end of stream: back to the initial decode state
        if (clear) begin
            phase_next   = 1'b0;
            flags_next   = '0;
            rem_next     = '0;
            low_next     = '0;
            emitted_next = '0;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= 1'b0;
            flags_reg   <= '0;
            rem_reg     <= '0;
            low_reg     <= '0;
            emitted_reg <= '0;
            cnt_reg     <= '0;
            src_reg     <= '0;
            last_reg    <= 1'b0;
            mv_reg      <= 1'b0;
            mbyte_reg   <= '0;
            mlast_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            flags_reg   <= flags_next;
            rem_reg     <= rem_next;
            low_reg     <= low_next;
            emitted_reg <= emitted_next;
            cnt_reg     <= cnt_next;
            src_reg     <= src_next;
            last_reg    <= last_next;
            mv_reg      <= mv_next;
            mbyte_reg   <= mbyte_next;
            mlast_reg   <= mlast_next;
        end
    end

    // output limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    assign m_valid    = mv_reg;
    assign m_out_byte = mbyte_reg;
    assign m_run_last = mlast_reg;

    // checks
    `LZFBD_ASSERT_IMP(a_copy_cnt, aclk, aresetn, state_reg == ST_COPY, cnt_reg != '0,
        "copy running with zero count")
    `LZFBD_ASSERT_NXT(a_pair_copy, aclk, aresetn, s_fire && phase_reg,
        state_reg == ST_COPY, "pair high byte did not start a copy")
    `LZFBD_ASSERT_NXT(a_last_clear, aclk, aresetn, s_fire && s_in_last && !phase_reg,
        rem_reg == '0 && emitted_reg == '0 && !phase_reg, "stream end did not restart")
    `LZFBD_ASSERT_IMP(a_rem_range, aclk, aresetn, 1'b1, rem_reg <= FLAGS_PER_BYTE,
        "flag count out of range")

endmodule

FILE: src/lzss_fbd_ram.sv
// ----------------------------------------------------------------------------
// lzss_fbd_ram
// generic single-write, single-read ram with registered read (old data)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzss_fbd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/lzss_fbd_hist.sv
// ----------------------------------------------------------------------------
// lzss_fbd_hist
// history ring: write pointer, fill tracking and read-after-write forwarding
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzss_fbd_hist #(
    parameter int unsigned HISTORY_DEPTH = lzss_fbd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             clear,
    input  lzss_fbd_pkg::hist_req_t          req,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] rd_addr,
    output logic [$clog2(HISTORY_DEPTH)-1:0] wr_pos,
    output logic [lzss_fbd_pkg::BYTE_W-1:0]  rd_data
);
    import lzss_fbd_pkg::*;

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(HISTORY_DEPTH - 1);

    logic [AW-1:0]     wp_reg, wp_next;
    logic              full_reg, full_next;
    logic              hit_reg, ok_reg;
    logic [BYTE_W-1:0] fwd_reg;
    logic [BYTE_W-1:0] ram_q;
    logic              rd_hit, rd_ok;

    // ring storage
    lzss_fbd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (req.wr_en),
        .waddr (wp_reg),
        .wdata (req.wr_data),
        .re    (req.rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // entries below the write pointer, or all once wrapped, hold stream data
    assign rd_hit = req.wr_en && (rd_addr == wp_reg);
    assign rd_ok  = full_reg || (rd_addr < wp_reg);

    // write pointer and fill state
    always_comb begin
        wp_next   = wp_reg;
        full_next = full_reg;
        if (req.wr_en) begin
            wp_next = wp_reg + AW'(1);
            if (wp_reg == LAST_POS) begin
                full_next = 1'b1;
            end
        end
        if (clear) begin
            wp_next   = '0;
            full_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            full_reg <= 1'b0;
            hit_reg  <= 1'b0;
            ok_reg   <= 1'b0;
        end else begin
            wp_reg   <= wp_next;
            full_reg <= full_next;
            if (req.rd_en) begin
                hit_reg <= rd_hit;
                ok_reg  <= rd_ok;
            end
        end
    end

    // forwarded byte for a read of the entry written in the same cycle
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            fwd_reg <= req.wr_data;
        end
    end

    assign wr_pos  = wp_reg;
    assign rd_data = hit_reg ? fwd_reg : (ok_reg ? ram_q : '0);

endmodule

FILE: dv/lzss_fbd_checker.sv
// ----------------------------------------------------------------------------
// lzss_fbd_checker
// predicts the decompressed byte stream and compares it with the m_ channel
// ----------------------------------------------------------------------------
// Watches the configuration port and both handshakes. Every accepted s_ beat
// is decoded by a local model of the flag-byte lzss scheme (own history ring,
// flag shifter, pair assembly, per-stream output count and limit), and the
// bytes it yields are queued. Every accepted m_ beat is checked against the
// oldest queued byte, field by field. The failure count and the number of
// bytes still owed are handed to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzss_fbd_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lzss_fbd_pkg::LIMIT_W-1:0] cfg_wr_data,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [lzss_fbd_pkg::BYTE_W-1:0]  s_in_byte,
    input  logic                             s_in_last,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [lzss_fbd_pkg::BYTE_W-1:0]  m_out_byte,
    input  logic                             m_run_last,
    output int                               fail_count,
    output int                               pending
);
    import lzss_fbd_pkg::*;

    localparam int MAX_RUN = 17;

    typedef enum logic [1:0] {
        PH_TOKEN     = 2'd0,
        PH_PAIR_HIGH = 2'd1
    } token_phase_e;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              run_last;
    } out_beat_t;

    // decoder state
    logic [BYTE_W-1:0]   ring [HISTORY_DEPTH_DEF];
    logic [OFFSET_W-1:0] wr_pos;
    logic [BYTE_W-1:0]   flags;
    logic [3:0]          flags_left;
    token_phase_e        phase;
    logic [BYTE_W-1:0]   pair_low;
    logic [LIMIT_W-1:0]  emitted;
    logic [LIMIT_W-1:0]  out_limit;

    // decompressed bytes still owed by the block
    out_beat_t expected_bytes[$];

    // back to the start-of-stream state, ring zeroed
    task automatic clear_stream();
        for (int i = 0; i < HISTORY_DEPTH_DEF; i++) begin
            ring[i] = '0;
        end
        wr_pos     = '0;
        flags      = '0;
        flags_left = '0;
        phase      = PH_TOKEN;
        pair_low   = '0;
        emitted    = '0;
    endtask

    // decode one compressed byte and queue what it yields
    task automatic decode_beat(input logic [BYTE_W-1:0] b, input logic lst);
        logic [BYTE_W-1:0]   yield [MAX_RUN];
        int                  n;
        logic [15:0]         code;
        logic [OFFSET_W-1:0] src;
        logic [LEN_W-1:0]    len;
        logic [BYTE_W-1:0]   c;
        logic                lit;
        out_beat_t           beat;
        n = 0;
        if (phase == PH_PAIR_HIGH) begin
            // copy: read before write, so offset zero sees the oldest entry
            code = {b, pair_low};
            src  = wr_pos - (code[OFFSET_W-1:0] & OFFSET_MASK);
            len  = LEN_W'(code[15:LENGTH_SHIFT]) + LENGTH_BIAS;
            for (int i = 0; i < int'(len); i++) begin
                c = ring[src];
                ring[wr_pos] = c;
                wr_pos++;
                src++;
                if (emitted < out_limit) begin
                    yield[n] = c;
                    n++;
                    emitted++;
                end
            end
            phase = PH_TOKEN;
        end else if (flags_left == 0) begin
            flags      = b;
            flags_left = FLAGS_PER_BYTE;
            phase      = PH_TOKEN;
        end else begin
            lit        = flags[0];
            flags      = flags >> 1;
            flags_left = flags_left - 4'd1;
            if (lit) begin
                ring[wr_pos] = b;
                wr_pos++;
                if (emitted < out_limit) begin
                    yield[n] = b;
                    n++;
                    emitted++;
                end
                phase = PH_TOKEN;
            end else begin
                pair_low = b;
                phase    = PH_PAIR_HIGH;
            end
        end
        for (int i = 0; i < n; i++) begin
            beat.data     = yield[i];
            beat.run_last = (i == n - 1);
            expected_bytes.push_back(beat);
        end
        if (lst) begin
            clear_stream();
        end
    endtask

    // compare one output beat with the oldest owed byte
    task automatic check_beat(input logic [BYTE_W-1:0] data, input logic lst);
        out_beat_t want;
        if (expected_bytes.size() == 0) begin
            fail_count++;
            $display("%t: unexpected beat, expected none, actual out_byte %02h run_last %0b",
                     $time, data, lst);
            return;
        end
        want = expected_bytes.pop_front();
        if (want.data !== data) begin
            fail_count++;
            $display("%t: out_byte expected %02h actual %02h", $time, want.data, data);
        end
        if (want.run_last !== lst) begin
            fail_count++;
            $display("%t: run_last expected %0b actual %0b", $time, want.run_last, lst);
        end
    endtask

    // sample every handshake at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_stream();
            out_limit = LIMIT_RESET;
            expected_bytes.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                out_limit = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                decode_beat(s_in_byte, s_in_last);
            end
            if (m_valid && m_ready) begin
                check_beat(m_out_byte, m_run_last);
            end
        end
        pending = expected_bytes.size();
    end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the lzss flag-byte decompressor
// ----------------------------------------------------------------------------
// Sends a short directed stream set (byte extremes, literals, copies with
// offset zero, one and the far end of the ring, the longest copy, a dangling
// pair low byte, stream ends on every kind of token), then random streams
// under several output limits. Most random streams are well formed with
// random content; the rest is raw noise. Both sides idle at random, with
// stretches of back-to-back beats. Checking is done by lzss_fbd_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import lzss_fbd_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int NUM_PHASES      = 6;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } comp_byte_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [LIMIT_W-1:0] cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [BYTE_W-1:0]  s_in_byte;
    logic               s_in_last;
    logic               m_valid;
    logic               m_ready;
    logic [BYTE_W-1:0]  m_out_byte;
    logic               m_run_last;
    int                 fail_count;
    int                 pending;
    int                 cycles;
    int                 phase_items;

    comp_byte_t stream_q[$];

    lzss_flag_byte_decompressor_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_run_last  (m_run_last)
    );

    lzss_fbd_checker u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_run_last  (m_run_last),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run time guard
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stall before each beat, with calm stretches
    initial begin
        int stall;
        int calm;
        m_ready = 1'b0;
        calm    = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (calm > 0) begin
                stall = 0;
                calm--;
            end else if ($urandom_range(0, 19) == 0) begin
                calm  = $urandom_range(10, 60);
                stall = 0;
            end else begin
                stall = $urandom_range(0, 13);
            end
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // one compressed beat; entered and left at a falling edge, valid kept high
    task automatic send_byte(input comp_byte_t item, input logic no_gaps);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_in_byte = item.data;
        s_in_last = item.last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        phase_items++;
    endtask

    task automatic push_item(input logic [BYTE_W-1:0] data, input logic lst);
        stream_q.push_back(comp_byte_t'({data, lst}));
    endtask

    task automatic send_stream();
        logic no_gaps;
        no_gaps = ($urandom_range(0, 3) == 0);
        while (stream_q.size() > 0) begin
            send_byte(stream_q.pop_front(), no_gaps);
        end
    endtask

    // sender holds off until every owed byte is out and any copy has finished
    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    // random stream: mostly flag groups with random tokens, else raw noise
    task automatic make_stream();
        int                pick;
        int                groups;
        int                tokens;
        int                produced;
        int                span;
        int                ofs;
        int                n;
        logic [BYTE_W-1:0] flag;
        logic [3:0]        len_code;
        comp_byte_t        tail;
        pick     = $urandom_range(0, 9);
        produced = 0;
        if (pick < 8) begin
            groups = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
            tokens = 8;
            flag   = '0;
            for (int g = 0; g < groups; g++) begin
                flag = BYTE_W'($urandom);
                push_item(flag, 1'b0);
                tokens = (g == groups - 1) ? $urandom_range(0, 8) : 8;
                for (int t = 0; t < tokens; t++) begin
                    if (flag[t]) begin
                        push_item(BYTE_W'($urandom), 1'b0);
                        produced++;
                    end else begin
                        // offsets mostly into recent output, some zero, some anywhere
                        span = $urandom_range(0, 9);
                        if (span < 6) begin
                            ofs = $urandom_range(1, (produced < 1) ? 1 :
                                                    (produced > 64) ? 64 : produced);
                        end else if (span == 6) begin
                            ofs = 0;
                        end else begin
                            ofs = $urandom_range(0, 4095);
                        end
                        len_code = 4'($urandom);
                        push_item(ofs[7:0], 1'b0);
                        push_item({len_code, ofs[11:8]}, 1'b0);
                        produced += int'(len_code) + 2;
                    end
                end
            end
            // stream cut after the low byte of a pair
            if (pick == 7 && tokens < 8 && !flag[tokens]) begin
                push_item(BYTE_W'($urandom), 1'b0);
            end
        end else begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                push_item(BYTE_W'($urandom), $urandom_range(0, 7) == 0);
            end
        end
        tail      = stream_q.pop_back();
        tail.last = 1'b1;
        stream_q.push_back(tail);
    endtask

    // main sequence
    initial begin
        logic [LIMIT_W-1:0] limit_plan [NUM_PHASES];
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_in_byte   = '0;
        s_in_last   = 1'b0;
        phase_items = 0;
        limit_plan  = '{32'd1, 32'hFFFF_FFFF, 32'd7, 32'd0, 32'hFFFF_FFFE, 32'd3};
        limit_plan[3] = $urandom_range(20, 150);
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // directed: literal, literal, three pairs, literal, pair, literal
        push_item(8'hA3, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h01, 1'b0);     // offset one, longest copy
        push_item(8'hF0, 1'b0);
        push_item(8'h00, 1'b0);     // offset zero, shortest copy
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);     // far end of the ring
        push_item(8'h0F, 1'b0);
        push_item(8'h5A, 1'b0);
        push_item(8'h03, 1'b0);
        push_item(8'h30, 1'b0);
        push_item(8'hC3, 1'b0);
        // dangling pair low byte at the end of a stream
        push_item(8'h00, 1'b0);
        push_item(8'h10, 1'b1);
        // stream ending on its flag byte
        push_item(8'h01, 1'b1);
        // stream ending on a literal
        push_item(8'h01, 1'b0);
        push_item(8'h7E, 1'b1);
        // stream ending on a pair high byte
        push_item(8'h00, 1'b0);
        push_item(8'h02, 1'b0);
        push_item(8'h10, 1'b1);
        send_stream();

        // random streams under each output limit
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            write_limit(limit_plan[p]);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                make_stream();
                send_stream();
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
